// File: hdl/ppit_pkg.sv
// Shared constants, types and codes for the periodic polyline intersection test.
`default_nettype none
package ppit_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int VTX_AW       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W        = 64;
  localparam int CRD_IN_W     = 32;
  localparam int COORD_W      = 34;
  localparam int TOL_W        = 31;
  localparam int PER_W        = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  // shared multiplier: MUL_W x MUL_W, MUL_DIG bits of the second operand a step
  localparam int MUL_W     = 72;
  localparam int MUL_DIG   = 8;
  localparam int MUL_STEPS = MUL_W / MUL_DIG;
  localparam int MUL_CW    = $clog2(MUL_STEPS);

  localparam logic [1:0] OP_LOAD_L = 2'd0;
  localparam logic [1:0] OP_LOAD_R = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] s;
  } pt_t;

  typedef struct packed {
    logic done;
    logic hit;
  } seg_res_t;

endpackage
`default_nettype wire

// File: hdl/ppit_if.sv
// Valid/ready channel interfaces for input items and results.
`default_nettype none
interface ppit_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic signed [ppit_pkg::CRD_IN_W-1:0] x;
  logic signed [ppit_pkg::CRD_IN_W-1:0] s;
  logic [ppit_pkg::PER_W-1:0]         left_perimeter;
  logic [ppit_pkg::PER_W-1:0]         right_perimeter;
  logic                               left_valid;
  logic                               right_valid;

  modport source (output valid, op, x, s, left_perimeter, right_perimeter,
                  left_valid, right_valid, input ready);
  modport sink   (input valid, op, x, s, left_perimeter, right_perimeter,
                  left_valid, right_valid, output ready);
endinterface

interface ppit_out_if;
  logic valid;
  logic ready;
  logic intersect_res;
  logic precondition_failed;

  modport source (output valid, intersect_res, precondition_failed, input ready);
  modport sink   (input valid, intersect_res, precondition_failed, output ready);
endinterface
`default_nettype wire

// File: hdl/periodic_polyline_intersection_test.sv
// Top level: vertex stores, precondition check and segment pair sequencing.
`default_nettype none
// Loads: one transaction per cycle while idle, no result; ready again the next cycle.
// Evaluate with a failed precondition: result via S_DONE, once output is free.
// Evaluate otherwise: per segment pair a fetch, then up to 19 products on the
//   shared 72x72 digit-serial multiplier (8-bit digits); a strict crossing ends a
//   pair after 8 of them. Up to 3*(L-1)*(R-1) pairs; the first hit ends the search.
// Reset (rst_n low, synchronous): counts, overflow flag and tolerance (66) restored.
module periodic_polyline_intersection_test (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  ppit_in_if.sink                         in_ch,
  ppit_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [ppit_pkg::TOL_W-1:0] cfg_wdata
);

  localparam int AW = ppit_pkg::VTX_AW;
  localparam int CW = ppit_pkg::CNT_W;
  localparam int XW = ppit_pkg::COORD_W;

  // period shift applied to the right polyline: -P, 0, +P
  localparam logic [1:0] K_NEG  = 2'd0;
  localparam logic [1:0] K_ZERO = 2'd1;
  localparam logic [1:0] K_POS  = 2'd2;

  typedef enum logic [2:0] {S_IDLE, S_RD0, S_RD1, S_RD2, S_GO, S_WAIT, S_DONE} state_t;

  state_t                     state_r;
  logic [CW-1:0]              lcnt_r, rcnt_r;
  logic                       ovf_r;
  logic [ppit_pkg::TOL_W-1:0] tol_r;
  logic [ppit_pkg::PER_W-1:0] lp_r;
  logic [1:0]                 k_r;
  logic [AW-1:0]              li_r, rj_r;
  ppit_pkg::pt_t              pa_r, pb_r, pc_r, pd_r;
  logic                       res_hit_r, res_pf_r;
  logic                       out_valid_r, out_hit_r, out_pf_r;

  logic                       in_acc, l_we, r_we, fail, seg_start;
  logic [ppit_pkg::TOL_W-1:0] tol_eff;
  logic [ppit_pkg::PER_W-1:0] pdiff;
  logic [ppit_pkg::VTX_W-1:0] wdata, l_rdata, r_rdata;
  logic [AW-1:0]              l_raddr, r_raddr;
  logic signed [XW-1:0]       sh, lp_ext;
  logic                       last_j, last_i;
  ppit_pkg::seg_res_t         seg_res;

  // unpack a stored vertex: x in the upper half, s in the lower, s moved by the shift argument
  function automatic ppit_pkg::pt_t unpack(input logic [ppit_pkg::VTX_W-1:0] e,
                                           input logic signed [XW-1:0] shift);
    ppit_pkg::pt_t p;
    p.x = XW'(signed'(e[63:32]));
    p.s = XW'(signed'(e[31:0])) + shift;
    return p;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tol_eff     = (tol_r == '0) ? ppit_pkg::TOL_W'(1) : tol_r;

  always_comb begin
    pdiff = (in_ch.left_perimeter >= in_ch.right_perimeter)
          ? in_ch.left_perimeter - in_ch.right_perimeter
          : in_ch.right_perimeter - in_ch.left_perimeter;
    fail  = !in_ch.left_valid || !in_ch.right_valid
         || (lcnt_r < CW'(2)) || (rcnt_r < CW'(2)) || ovf_r
         || (in_ch.left_perimeter == '0) || (pdiff > tol_eff);
  end

  // vertex writes only while idle; a full store drops the vertex
  assign wdata = {in_ch.x, in_ch.s};
  assign l_we  = in_acc && (in_ch.op == ppit_pkg::OP_LOAD_L)
              && (lcnt_r != CW'(ppit_pkg::MAX_VERTICES));
  assign r_we  = in_acc && (in_ch.op == ppit_pkg::OP_LOAD_R)
              && (rcnt_r != CW'(ppit_pkg::MAX_VERTICES));

  // segment start vertex first, end vertex the cycle after
  assign l_raddr = (state_r == S_RD1) ? li_r + AW'(1) : li_r;
  assign r_raddr = (state_r == S_RD1) ? rj_r + AW'(1) : rj_r;

  assign lp_ext = signed'(XW'(lp_r));
  always_comb begin
    case (k_r)
      K_NEG:   sh = -lp_ext;
      K_ZERO:  sh = '0;
      K_POS:   sh = lp_ext;
      default: sh = '0;
    endcase
  end

  assign last_j    = (CW'(rj_r) + CW'(2)) >= rcnt_r;
  assign last_i    = (CW'(li_r) + CW'(2)) >= lcnt_r;
  assign seg_start = (state_r == S_GO);

  ppit_ram #(.DEPTH(ppit_pkg::MAX_VERTICES), .WIDTH(ppit_pkg::VTX_W)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (lcnt_r[AW-1:0]),
    .wdata (wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  ppit_ram #(.DEPTH(ppit_pkg::MAX_VERTICES), .WIDTH(ppit_pkg::VTX_W)) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (rcnt_r[AW-1:0]),
    .wdata (wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  ppit_seg u_seg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seg_start),
    .pa    (pa_r),
    .pb    (pb_r),
    .pc    (pc_r),
    .pd    (pd_r),
    .tol   (tol_eff),
    .res   (seg_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      ovf_r       <= 1'b0;
      tol_r       <= ppit_pkg::TOL_RESET;
      out_valid_r <= 1'b0;
      k_r         <= K_NEG;
      li_r        <= '0;
      rj_r        <= '0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      // in S_DONE the valid flag is handled by the state itself
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_ch.op)
              ppit_pkg::OP_LOAD_L: begin
                if (l_we) lcnt_r <= lcnt_r + CW'(1);
                else      ovf_r  <= 1'b1;
              end
              ppit_pkg::OP_LOAD_R: begin
                if (r_we) rcnt_r <= rcnt_r + CW'(1);
                else      ovf_r  <= 1'b1;
              end
              ppit_pkg::OP_EVAL: begin
                lp_r <= in_ch.left_perimeter;
                k_r  <= K_NEG;
                li_r <= '0;
                rj_r <= '0;
                if (fail) begin
                  res_hit_r <= 1'b1;
                  res_pf_r  <= 1'b1;
                  state_r   <= S_DONE;
                end else begin
                  state_r <= S_RD0;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          pa_r    <= unpack(l_rdata, '0);
          pc_r    <= unpack(r_rdata, sh);
          state_r <= S_RD2;
        end
        S_RD2: begin
          pb_r    <= unpack(l_rdata, '0);
          pd_r    <= unpack(r_rdata, sh);
          state_r <= S_GO;
        end
        S_GO: state_r <= S_WAIT;
        S_WAIT: begin
          if (seg_res.done) begin
            res_pf_r <= 1'b0;
            if (seg_res.hit) begin
              res_hit_r <= 1'b1;
              state_r   <= S_DONE;
            end else if (!last_j) begin
              rj_r    <= rj_r + AW'(1);
              state_r <= S_RD0;
            end else if (!last_i) begin
              rj_r    <= '0;
              li_r    <= li_r + AW'(1);
              state_r <= S_RD0;
            end else if (k_r != K_POS) begin
              rj_r    <= '0;
              li_r    <= '0;
              k_r     <= k_r + 2'd1;
              state_r <= S_RD0;
            end else begin
              res_hit_r <= 1'b0;
              state_r   <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hold the verdict until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= res_hit_r;
            out_pf_r    <= res_pf_r;
            lcnt_r      <= '0;
            rcnt_r      <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.intersect_res       = out_hit_r;
  assign out_ch.precondition_failed = out_pf_r;

  a_pf_forces_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hit_r || !out_pf_r))
    else $error("precondition failure reported without intersect");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (lcnt_r <= CW'(ppit_pkg::MAX_VERTICES)) && (rcnt_r <= CW'(ppit_pkg::MAX_VERTICES)))
    else $error("vertex count beyond store depth");

  a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ((lcnt_r == '0) && (rcnt_r == '0) && !ovf_r))
    else $error("stores not emptied with the result");

  a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD0) |-> (((CW'(li_r) + CW'(1)) < lcnt_r)
                          && ((CW'(rj_r) + CW'(1)) < rcnt_r)))
    else $error("segment fetch beyond stored vertices");

  a_seg_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    seg_res.done |-> (state_r == S_WAIT))
    else $error("segment result outside wait state");

endmodule
`default_nettype wire

// File: hdl/ppit_ram.sv
// Generic simple dual-port RAM, registered read.
`default_nettype none
module ppit_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/ppit_mul.sv
// Digit-serial unsigned multiplier, MUL_DIG bits of opb per cycle while busy.
`default_nettype none
module ppit_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ppit_pkg::MUL_W-1:0]   opa,
  input  wire logic [ppit_pkg::MUL_W-1:0]   opb,
  output logic                              done,
  output logic [2*ppit_pkg::MUL_W-1:0]      prod
);

  localparam int W  = ppit_pkg::MUL_W;
  localparam int DG = ppit_pkg::MUL_DIG;

  logic [W-1:0]          a_r;
  logic [W-1:0]          b_r;
  logic [2*W-1:0]        acc_r;
  logic [ppit_pkg::MUL_CW-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [W+DG-1:0]       pp;
  logic [2*W+DG-1:0]     sum;
  logic [2*W-1:0]        acc_nxt;

  // add the partial product at the top, then shift one digit down
  always_comb begin
    pp      = a_r * b_r[DG-1:0];
    sum     = {{DG{1'b0}}, acc_r} + {pp, {W{1'b0}}};
    acc_nxt = sum[2*W+DG-1:DG];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= opa;
        b_r    <= opb;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= b_r >> DG;
        cnt_r <= cnt_r + ppit_pkg::MUL_CW'(1);
        if (cnt_r == ppit_pkg::MUL_CW'(ppit_pkg::MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// File: hdl/ppit_seg.sv
// Segment pair test: crossing signs and tolerance touch over a shared multiplier.
`default_nettype none
module ppit_seg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire ppit_pkg::pt_t               pa,
  input  wire ppit_pkg::pt_t               pb,
  input  wire ppit_pkg::pt_t               pc,
  input  wire ppit_pkg::pt_t               pd,
  input  wire logic [ppit_pkg::TOL_W-1:0]  tol,
  output ppit_pkg::seg_res_t               res
);

  localparam int DW = ppit_pkg::COORD_W + 1;
  localparam int MW = ppit_pkg::MUL_W;
  localparam int BW = ppit_pkg::COORD_W + 2;
  localparam logic [MW-1:0] UNIT2 = MW'(1) << 32;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_EVAL} state_t;
  typedef enum logic [4:0] {
    U_C1P, U_C1Q, U_C2P, U_C2Q, U_C3P, U_C3Q, U_C4P, U_C4Q,
    U_LABX, U_LABS, U_LCDX, U_LCDS, U_TOL2, U_RHSAB, U_RHSCD,
    U_SQ1, U_SQ2, U_SQ3, U_SQ4
  } uop_t;

  state_t state_r;
  uop_t   uop_r;
  ppit_pkg::pt_t a_r, b_r, c_r, d_r;
  logic [ppit_pkg::TOL_W-1:0] tol_r;
  logic signed [DW-1:0] ab_x, ab_s, cd_x, cd_s, ac_x, ac_s, ad_x, ad_s;
  logic signed [DW-1:0] ca_x, ca_s, cb_x, cb_s;
  logic signed [MW-1:0] prod_r;
  logic signed [MW-1:0] cr_r [4];
  logic [MW-1:0]        lab_r, lcd_r, tol2_r;
  logic [2*MW-1:0]      rhs_ab_r, rhs_cd_r;
  logic [3:0]           nc_r;
  ppit_pkg::seg_res_t   res_r;

  logic [MW-1:0]   ma, mb, pm, scale_ab, scale_cd;
  logic            neg, proper, near_any, mul_start, mul_done;
  logic [2*MW-1:0] mul_prod;
  logic [3:0]      cpos, cneg;

  function automatic logic [MW-1:0] dmag(input logic signed [DW-1:0] d);
    logic [DW-1:0] u;
    u = d[DW-1] ? DW'(-d) : DW'(d);
    return MW'(u);
  endfunction

  function automatic logic [MW-1:0] cmag(input logic signed [MW-1:0] c);
    return c[MW-1] ? MW'(-c) : MW'(c);
  endfunction

  function automatic logic in_box(input ppit_pkg::pt_t p, input ppit_pkg::pt_t e0,
                                  input ppit_pkg::pt_t e1,
                                  input logic [ppit_pkg::TOL_W-1:0] t);
    logic signed [BW-1:0] px, ps, x0, x1, s0, s1, tw;
    px = BW'(p.x);  ps = BW'(p.s);
    x0 = BW'(e0.x); x1 = BW'(e1.x);
    s0 = BW'(e0.s); s1 = BW'(e1.s);
    tw = signed'(BW'(t));
    return (px >= ((x0 < x1) ? x0 : x1) - tw) && (px <= ((x0 > x1) ? x0 : x1) + tw)
        && (ps >= ((s0 < s1) ? s0 : s1) - tw) && (ps <= ((s0 > s1) ? s0 : s1) + tw);
  endfunction

  always_comb begin
    scale_ab = (lab_r > UNIT2) ? lab_r : UNIT2;
    scale_cd = (lcd_r > UNIT2) ? lcd_r : UNIT2;
    for (int k = 0; k < 4; k++) begin
      cneg[k] = cr_r[k][MW-1];
      cpos[k] = !cr_r[k][MW-1] && (cr_r[k] != '0);
    end
    proper = ((cpos[0] && cneg[1]) || (cneg[0] && cpos[1]))
          && ((cpos[2] && cneg[3]) || (cneg[2] && cpos[3]));
    near_any = (nc_r[0] && in_box(c_r, a_r, b_r, tol_r))
            || (nc_r[1] && in_box(d_r, a_r, b_r, tol_r))
            || (nc_r[2] && in_box(a_r, c_r, d_r, tol_r))
            || (nc_r[3] && in_box(b_r, c_r, d_r, tol_r));
  end

  // operand selection per micro-op; neg is the sign of a signed product
  always_comb begin
    ma  = '0;
    mb  = '0;
    neg = 1'b0;
    case (uop_r)
      U_C1P:   begin ma = dmag(ab_x); mb = dmag(ac_s); neg = ab_x[DW-1] ^ ac_s[DW-1]; end
      U_C1Q:   begin ma = dmag(ab_s); mb = dmag(ac_x); neg = ab_s[DW-1] ^ ac_x[DW-1]; end
      U_C2P:   begin ma = dmag(ab_x); mb = dmag(ad_s); neg = ab_x[DW-1] ^ ad_s[DW-1]; end
      U_C2Q:   begin ma = dmag(ab_s); mb = dmag(ad_x); neg = ab_s[DW-1] ^ ad_x[DW-1]; end
      U_C3P:   begin ma = dmag(cd_x); mb = dmag(ca_s); neg = cd_x[DW-1] ^ ca_s[DW-1]; end
      U_C3Q:   begin ma = dmag(cd_s); mb = dmag(ca_x); neg = cd_s[DW-1] ^ ca_x[DW-1]; end
      U_C4P:   begin ma = dmag(cd_x); mb = dmag(cb_s); neg = cd_x[DW-1] ^ cb_s[DW-1]; end
      U_C4Q:   begin ma = dmag(cd_s); mb = dmag(cb_x); neg = cd_s[DW-1] ^ cb_x[DW-1]; end
      U_LABX:  begin ma = dmag(ab_x); mb = dmag(ab_x); end
      U_LABS:  begin ma = dmag(ab_s); mb = dmag(ab_s); end
      U_LCDX:  begin ma = dmag(cd_x); mb = dmag(cd_x); end
      U_LCDS:  begin ma = dmag(cd_s); mb = dmag(cd_s); end
      U_TOL2:  begin ma = MW'(tol_r); mb = MW'(tol_r); end
      U_RHSAB: begin ma = scale_ab; mb = tol2_r; end
      U_RHSCD: begin ma = scale_cd; mb = tol2_r; end
      U_SQ1:   begin ma = cmag(cr_r[0]); mb = cmag(cr_r[0]); end
      U_SQ2:   begin ma = cmag(cr_r[1]); mb = cmag(cr_r[1]); end
      U_SQ3:   begin ma = cmag(cr_r[2]); mb = cmag(cr_r[2]); end
      U_SQ4:   begin ma = cmag(cr_r[3]); mb = cmag(cr_r[3]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign mul_start = (state_r == S_ISSUE) && !((uop_r == U_LABX) && proper);
  assign pm        = mul_prod[MW-1:0];

  ppit_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .opa   (ma),
    .opb   (mb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      uop_r   <= U_C1P;
      res_r   <= '0;
    end else begin
      res_r.done <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            a_r <= pa; b_r <= pb; c_r <= pc; d_r <= pd; tol_r <= tol;
            ab_x <= DW'(pb.x) - DW'(pa.x); ab_s <= DW'(pb.s) - DW'(pa.s);
            cd_x <= DW'(pd.x) - DW'(pc.x); cd_s <= DW'(pd.s) - DW'(pc.s);
            ac_x <= DW'(pc.x) - DW'(pa.x); ac_s <= DW'(pc.s) - DW'(pa.s);
            ad_x <= DW'(pd.x) - DW'(pa.x); ad_s <= DW'(pd.s) - DW'(pa.s);
            ca_x <= DW'(pa.x) - DW'(pc.x); ca_s <= DW'(pa.s) - DW'(pc.s);
            cb_x <= DW'(pb.x) - DW'(pc.x); cb_s <= DW'(pb.s) - DW'(pc.s);
            uop_r   <= U_C1P;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          // a strict crossing settles the pair before the touch test
          if ((uop_r == U_LABX) && proper) begin
            res_r   <= '{done: 1'b1, hit: 1'b1};
            state_r <= S_IDLE;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mul_done) begin
            case (uop_r)
              U_C1P, U_C2P, U_C3P, U_C4P: prod_r <= neg ? -signed'(pm) : signed'(pm);
              U_C1Q: cr_r[0] <= neg ? prod_r + signed'(pm) : prod_r - signed'(pm);
              U_C2Q: cr_r[1] <= neg ? prod_r + signed'(pm) : prod_r - signed'(pm);
              U_C3Q: cr_r[2] <= neg ? prod_r + signed'(pm) : prod_r - signed'(pm);
              U_C4Q: cr_r[3] <= neg ? prod_r + signed'(pm) : prod_r - signed'(pm);
              U_LABX, U_LCDX: prod_r <= signed'(pm);
              U_LABS:  lab_r    <= MW'(prod_r) + pm;
              U_LCDS:  lcd_r    <= MW'(prod_r) + pm;
              U_TOL2:  tol2_r   <= pm;
              U_RHSAB: rhs_ab_r <= mul_prod;
              U_RHSCD: rhs_cd_r <= mul_prod;
              U_SQ1:   nc_r[0]  <= mul_prod <= rhs_ab_r;
              U_SQ2:   nc_r[1]  <= mul_prod <= rhs_ab_r;
              U_SQ3:   nc_r[2]  <= mul_prod <= rhs_cd_r;
              U_SQ4:   nc_r[3]  <= mul_prod <= rhs_cd_r;
              default: prod_r   <= prod_r;
            endcase
            if (uop_r == U_SQ4) begin
              state_r <= S_EVAL;
            end else begin
              uop_r   <= uop_t'(5'(uop_r) + 5'd1);
              state_r <= S_ISSUE;
            end
          end
        end
        S_EVAL: begin
          res_r   <= '{done: 1'b1, hit: near_any};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire
